FILE: rtl/learned_peak_tracker_core_macros.svh
// Assertion helpers for the learned peak tracker.
// Each expects clk and arst_n in scope.
`ifndef LEARNED_PEAK_TRACKER_CORE_MACROS_SVH
`define LEARNED_PEAK_TRACKER_CORE_MACROS_SVH

// same-cycle implication
`define LPT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LPT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/lpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpt_pkg
// Shared types and constants for the learned peak tracker.
// ----------------------------------------------------------------------------
package lpt_pkg;

	localparam int unsigned DATA_W          = 16;
	localparam int unsigned STAGE_DEPTH_DEF = 2;
	localparam logic [DATA_W-1:0] LIMIT_RST = 16'd1023;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_LOAD   = 1'b1;

	typedef logic [DATA_W-1:0] data_t;

	// second-stage buffer control from the update logic
	typedef struct packed {
		logic wr;   // append first-stage peak at current fill
		logic clr;  // flush: clear all entries
	} sec_ctl_t;

endpackage

FILE: rtl/lpt_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpt_update
// Next-state logic: applies one item to the running max and the two buffers.
// ----------------------------------------------------------------------------
module lpt_update #(
	parameter int unsigned STAGE_DEPTH = lpt_pkg::STAGE_DEPTH_DEF,
	parameter int unsigned FILL_W      = $clog2(STAGE_DEPTH + 1)
) (
	input  logic                                     opcode,
	input  lpt_pkg::data_t                           sample,
	input  lpt_pkg::data_t                           upper_limit,
	input  lpt_pkg::data_t                           max_cur,
	input  logic [FILL_W-1:0]                        first_fill,
	input  lpt_pkg::data_t                           first_peak,
	input  logic [FILL_W-1:0]                        sec_fill,
	input  logic [STAGE_DEPTH-1:0][lpt_pkg::DATA_W-1:0] sec_stage,
	output lpt_pkg::data_t                           max_nxt,
	output logic [FILL_W-1:0]                        first_fill_nxt,
	output lpt_pkg::data_t                           first_peak_nxt,
	output logic [FILL_W-1:0]                        sec_fill_nxt,
	output lpt_pkg::sec_ctl_t                        sec_ctl
);
	import lpt_pkg::*;

	localparam logic [FILL_W-1:0] FULL = FILL_W'(STAGE_DEPTH);

	data_t flush_max;

	// largest second-stage entry strictly between max and limit
	always_comb begin
		flush_max = max_cur;
		for (int i = 0; i < STAGE_DEPTH; i++) begin
			if (sec_stage[i] > flush_max && sec_stage[i] < upper_limit)
				flush_max = sec_stage[i];
		end
	end

	always_comb begin
		max_nxt        = max_cur;
		first_fill_nxt = first_fill;
		first_peak_nxt = first_peak;
		sec_fill_nxt   = sec_fill;
		sec_ctl        = '0;
		priority if (opcode == OP_LOAD) begin
			max_nxt = sample;
		end else if (sample == '0) begin
			// no change
		end else if (sample >= max_cur) begin
			max_nxt = sample;
		end else if (sample > upper_limit) begin
			// outlier
		end else if (max_cur > upper_limit) begin
			max_nxt = '0;
		end else if (first_fill != FULL) begin
			first_fill_nxt = first_fill + 1'b1;
			if (sample > first_peak)
				first_peak_nxt = sample;
		end else begin
			// first stage full: sample dropped, peak moves on
			first_fill_nxt = '0;
			first_peak_nxt = '0;
			if (sec_fill != FULL) begin
				sec_ctl.wr   = 1'b1;
				sec_fill_nxt = sec_fill + 1'b1;
			end else begin
				sec_ctl.clr  = 1'b1;
				sec_fill_nxt = '0;
				max_nxt      = flush_max;
			end
		end
	end

endmodule

FILE: rtl/learned_peak_tracker_core.sv
`timescale 1ns / 1ps
`include "learned_peak_tracker_core_macros.svh"
// ----------------------------------------------------------------------------
// learned_peak_tracker_core
// Learns the full-scale max of an ADC stream with two-stage outlier rejection.
// ----------------------------------------------------------------------------
// Takes one item per clock while in_stall is low and returns one result per
// item, passing through the input register and then the result register. The
// buffer update and the max compare over the second stage are combinational
// between those registers; the first stage is kept as a fill count plus its
// running peak. in_stall rises only while a result is held by out_stall and
// the input register is occupied. upper_limit resets to 1023.
module learned_peak_tracker_core #(
	parameter int unsigned STAGE_DEPTH = lpt_pkg::STAGE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_wr_en,
	input  lpt_pkg::data_t cfg_wr_data,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic           opcode,
	input  lpt_pkg::data_t sample_value,
	output logic           out_valid,
	input  logic           out_stall,
	output lpt_pkg::data_t learned_max
);
	import lpt_pkg::*;

	localparam int unsigned FILL_W = $clog2(STAGE_DEPTH + 1);

	data_t             limit_q;
	logic              s1_valid_q;
	logic              opcode_s1;
	data_t             sample_s1;
	logic              out_valid_q;
	data_t             learned_max_q;

	data_t             max_q;
	logic [FILL_W-1:0] first_fill_q;
	data_t             first_peak_q;
	logic [FILL_W-1:0] sec_fill_q;
	logic [STAGE_DEPTH-1:0][DATA_W-1:0] sec_stage_q;

	data_t             max_nxt;
	logic [FILL_W-1:0] first_fill_nxt;
	data_t             first_peak_nxt;
	logic [FILL_W-1:0] sec_fill_nxt;
	sec_ctl_t          sec_ctl;

	logic              s1_adv;
	logic              upd;

	assign s1_adv   = !out_valid_q || !out_stall;
	assign in_stall = s1_valid_q && !s1_adv;
	assign upd      = s1_valid_q && s1_adv;

	assign out_valid   = out_valid_q;
	assign learned_max = learned_max_q;

	lpt_update #(
		.STAGE_DEPTH (STAGE_DEPTH),
		.FILL_W      (FILL_W)
	) u_update (
		.opcode         (opcode_s1),
		.sample         (sample_s1),
		.upper_limit    (limit_q),
		.max_cur        (max_q),
		.first_fill     (first_fill_q),
		.first_peak     (first_peak_q),
		.sec_fill       (sec_fill_q),
		.sec_stage      (sec_stage_q),
		.max_nxt        (max_nxt),
		.first_fill_nxt (first_fill_nxt),
		.first_peak_nxt (first_peak_nxt),
		.sec_fill_nxt   (sec_fill_nxt),
		.sec_ctl        (sec_ctl)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RST;
		end else if (cfg_wr_en) begin
			limit_q <= cfg_wr_data;
		end
	end

	// handshake control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!in_stall)
				s1_valid_q <= in_valid;
			if (s1_adv)
				out_valid_q <= s1_valid_q;
		end
	end

	// input and result registers, no reset
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			opcode_s1 <= opcode;
			sample_s1 <= sample_value;
		end
		if (upd)
			learned_max_q <= max_nxt;
	end

	// tracker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q        <= '0;
			first_fill_q <= '0;
			first_peak_q <= '0;
			sec_fill_q   <= '0;
			sec_stage_q  <= '0;
		end else if (upd) begin
			max_q        <= max_nxt;
			first_fill_q <= first_fill_nxt;
			first_peak_q <= first_peak_nxt;
			sec_fill_q   <= sec_fill_nxt;
			for (int i = 0; i < STAGE_DEPTH; i++) begin
				if (sec_ctl.clr)
					sec_stage_q[i] <= '0;
				else if (sec_ctl.wr && sec_fill_q == FILL_W'(i))
					sec_stage_q[i] <= first_peak_q;
			end
		end
	end

	`LPT_ASSERT_NOW(a_first_fill_range, 1'b1, first_fill_q <= FILL_W'(STAGE_DEPTH), "first fill overrun")
	`LPT_ASSERT_NOW(a_sec_fill_range, 1'b1, sec_fill_q <= FILL_W'(STAGE_DEPTH), "second fill overrun")
	`LPT_ASSERT_NOW(a_empty_peak, first_fill_q == '0, first_peak_q == '0, "stale first-stage peak")
	`LPT_ASSERT_NEXT(a_in_capture, in_valid && !in_stall, s1_valid_q, "input transfer lost")

endmodule
